@@ hdl/zad_pkg.sv @@
// Package for the running z-score anomaly detector.
// Holds item structs, opcodes, result codes and default sizes.
// No dependencies.
package zad_pkg;

    localparam int LENGTH_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF    = 20;
    localparam int INTERVAL_BITS_DEF = 20;
    localparam int ENTROPY_W         = 16;
    localparam int SCORE_DIV         = 3;

    localparam logic [15:0] Z_THRESHOLD_RST = 16'd768;
    localparam logic [19:0] MIN_SAMPLES_RST = 20'd100;
    localparam logic [15:0] SCORE_ONE       = 16'd32768;
    localparam logic [15:0] Z_MAX           = 16'hFFFF;
    localparam logic [23:0] STAT_MAX        = 24'hFFFFFF;
    localparam logic [31:0] TOTAL_MAX       = 32'hFFFF_FFFF;

    localparam logic [1:0] OP_ANALYZE = 2'd0;
    localparam logic [1:0] OP_RECORD  = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [1:0] TYPE_NONE    = 2'd0;
    localparam logic [1:0] TYPE_LENGTH  = 2'd1;
    localparam logic [1:0] TYPE_ENTROPY = 2'd2;
    localparam logic [1:0] TYPE_TIMING  = 2'd3;

    localparam logic [1:0] FEAT_LEN = 2'd0;
    localparam logic [1:0] FEAT_ENT = 2'd1;
    localparam logic [1:0] FEAT_IV  = 2'd2;

    localparam logic [1:0] CFG_Z_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_MIN_SAMPLES = 2'd1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] request_length;
        logic [15:0] entropy_value;
        logic [47:0] timestamp_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  anomaly_type;
        logic [15:0] anomaly_score;
        logic [15:0] length_z;
        logic        warming_up;
        logic [23:0] mean_length;
        logic [23:0] stddev_length;
        logic [31:0] anomaly_total;
        logic [31:0] analyzed_total;
    } t_out_item;

endpackage

@@ hdl/zad_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Dividend arrives left aligned; i_bits sets the iteration count.
// No dependencies.
module zad_div #(
    parameter int DW = 76,
    parameter int VW = 28,
    parameter int CW = $clog2(DW + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [CW-1:0] i_bits,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [DW-1:0] r_quot;
    logic [VW:0]   w_sh;
    logic [VW:0]   w_dif;
    logic          w_ge;

    assign w_sh  = {r_rem, r_quot[DW-1]};
    assign w_ge  = w_sh >= {1'b0, r_div};
    assign w_dif = w_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_bits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_dif[VW-1:0] : w_sh[VW-1:0];
            r_quot <= {r_quot[DW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ hdl/zad_sqrt.sv @@
// Digit-serial integer square root, two radicand bits per cycle.
// Gives floor(sqrt(i_value)) on o_root when o_done pulses.
// No dependencies.
module zad_sqrt #(
    parameter int W = 56
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [W-1:0]     i_value,
    output logic             o_done,
    output logic [W/2-1:0]   o_root
);

    localparam int R  = W / 2;
    localparam int CW = $clog2(R + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_val;
    logic [R:0]    r_rem;
    logic [R-1:0]  r_root;
    logic [R+2:0]  w_sh;
    logic [R+2:0]  w_trial;
    logic [R+2:0]  w_dif;
    logic          w_ge;

    assign w_sh    = {r_rem, r_val[W-1:W-2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ge    = w_sh >= w_trial;
    assign w_dif   = w_sh - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(R);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[W-3:0], 2'b00};
            r_rem  <= w_ge ? w_dif[R:0] : w_sh[R:0];
            r_root <= {r_root[R-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

@@ hdl/zscore_anomaly_detector_core.sv @@
// Top level of the running z-score anomaly detector.
// Depends on zad_pkg, zad_div and zad_sqrt.
//
// One item is in flight at a time. For each of the three features (length,
// entropy, interval) the block runs mean, scaled square-mean, variance square
// root, z-score and score through one shared bit-serial divider and one
// square-root unit. Per feature the steps run in order: mean division,
// square-mean division, mean square, square root, z-score division and
// score division. After the interval feature the block waits in S_DONE
// until the output register is free, so an output stall holds off the
// next acceptance.
// The result sits in an output register; a new item is taken once the
// block is back in idle.
module zscore_anomaly_detector_core
    import zad_pkg::*;
#(
    parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF,
    parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    localparam int X_W0   = (LENGTH_BITS > ENTROPY_W) ? LENGTH_BITS : ENTROPY_W;
    localparam int X_W    = (X_W0 > INTERVAL_BITS) ? X_W0 : INTERVAL_BITS;
    localparam int MEAN_W = X_W + 8;
    localparam int SUM_W  = X_W + COUNT_BITS;
    localparam int SQ_W   = 2 * X_W + COUNT_BITS;
    localparam int VAR_W  = 2 * MEAN_W;
    localparam int DIV_W  = SQ_W + 16;
    localparam int VW     = (COUNT_BITS > MEAN_W) ? COUNT_BITS : MEAN_W;
    localparam int CW     = $clog2(DIV_W + 1);
    localparam int MW     = (COUNT_BITS > 20) ? COUNT_BITS : 20;
    localparam int PAD_M  = DIV_W - SUM_W;
    localparam int PAD_Z  = DIV_W - MEAN_W;
    localparam int PAD_S  = DIV_W - 16;

    localparam logic [X_W-1:0]        LEN_MAX = X_W'((1 << LENGTH_BITS) - 1);
    localparam logic [X_W-1:0]        IV_MAX  = X_W'((1 << INTERVAL_BITS) - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MEAN  = 8'b0000_0010,
        S_VAR   = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_SQRT  = 8'b0001_0000,
        S_Z     = 8'b0010_0000,
        S_SCORE = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_go;
    logic [1:0] r_feat;

    logic [15:0]           r_zthr;
    logic [19:0]           r_mins;
    logic [COUNT_BITS-1:0] r_cnt_s;
    logic [COUNT_BITS-1:0] r_cnt_i;
    logic [SUM_W-1:0]      r_sum [3];
    logic [SQ_W-1:0]       r_sq  [3];
    logic [47:0]           r_last;
    logic [31:0]           r_ana;
    logic [31:0]           r_anom;

    logic [1:0]        r_op;
    logic [X_W-1:0]    r_xv  [3];
    logic [2*X_W-1:0]  r_xsq [3];
    logic [47:0]       r_now;
    logic              r_warm;
    logic [MEAN_W-1:0] r_mean;
    logic [VAR_W-1:0]  r_q;
    logic [VAR_W-1:0]  r_mm;
    logic [MEAN_W-1:0] r_sd;
    logic [15:0]       r_z;
    logic [15:0]       r_best;
    logic [1:0]        r_type;
    logic [MEAN_W-1:0] r_lmean;
    logic [MEAN_W-1:0] r_lsd;
    logic [15:0]       r_lz;
    t_out_item         r_out;
    logic              r_out_valid;

    logic                  w_in_acc;
    logic                  w_out_free;
    logic                  w_fire;
    logic [COUNT_BITS-1:0] w_n;
    logic [X_W-1:0]        w_len;
    logic [X_W-1:0]        w_iv;
    logic [47:0]           w_dt;
    logic                  w_warm;
    logic [MEAN_W-1:0]     w_xq;
    logic [MEAN_W-1:0]     w_dist;
    logic [15:0]           w_diff;
    logic                  w_div_start;
    logic [CW-1:0]         w_div_bits;
    logic [DIV_W-1:0]      w_dvd;
    logic [VW-1:0]         w_dvs;
    logic                  w_div_done;
    logic [DIV_W-1:0]      w_quot;
    logic                  w_sqrt_start;
    logic [VAR_W-1:0]      w_var;
    logic                  w_sqrt_done;
    logic [MEAN_W-1:0]     w_root;
    logic [MEAN_W-1:0]     w_mean;
    logic [15:0]           w_z;
    logic [15:0]           w_s;
    logic                  w_judge;
    logic [1:0]            w_ftype;
    logic                  w_det;
    logic                  w_rec;
    logic [31:0]           w_ana_nx;
    logic [31:0]           w_anom_nx;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_fire     = (r_state == S_DONE) && w_out_free;
    assign w_n        = (r_feat == FEAT_IV) ? r_cnt_i : r_cnt_s;

    assign w_len  = (X_W'(i_in_data.request_length) > LEN_MAX)
                    ? LEN_MAX : X_W'(i_in_data.request_length);
    assign w_dt   = i_in_data.timestamp_ms - r_last;
    assign w_iv   = (i_in_data.timestamp_ms < r_last || w_dt > 48'(IV_MAX))
                    ? IV_MAX : w_dt[X_W-1:0];
    assign w_warm = MW'(r_cnt_s) < MW'(r_mins);

    assign w_xq   = {r_xv[r_feat], 8'h00};
    assign w_dist = (w_xq > r_mean) ? w_xq - r_mean : r_mean - w_xq;
    assign w_diff = r_z - r_zthr;

    assign w_div_start  = !r_go && (r_state == S_MEAN || r_state == S_VAR ||
                                    r_state == S_Z || r_state == S_SCORE);
    assign w_sqrt_start = !r_go && (r_state == S_SQRT);
    assign w_var = (w_n > COUNT_BITS'(1) && r_q > r_mm) ? r_q - r_mm : '0;

    always_comb begin
        w_dvd      = '0;
        w_dvs      = '0;
        w_div_bits = '0;
        case (r_state)
            S_MEAN: begin
                w_dvd      = {r_sum[r_feat], {PAD_M{1'b0}}};
                w_dvs      = VW'(w_n);
                w_div_bits = CW'(SUM_W + 8);
            end
            S_VAR: begin
                w_dvd      = {r_sq[r_feat], 16'h0000};
                w_dvs      = VW'(w_n);
                w_div_bits = CW'(DIV_W);
            end
            S_Z: begin
                w_dvd      = {w_dist, {PAD_Z{1'b0}}};
                w_dvs      = VW'(r_sd);
                w_div_bits = CW'(MEAN_W + 8);
            end
            S_SCORE: begin
                w_dvd      = {w_diff, {PAD_S{1'b0}}};
                w_dvs      = VW'(SCORE_DIV);
                w_div_bits = CW'(23);
            end
            default: begin
                w_dvd = '0;
            end
        endcase
    end

    zad_div #(
        .DW (DIV_W),
        .VW (VW),
        .CW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_bits     (w_div_bits),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    zad_sqrt #(
        .W (VAR_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_value (w_var),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    assign w_mean  = (w_n == '0) ? '0 : w_quot[MEAN_W-1:0];
    assign w_z     = (r_sd == '0) ? 16'h0000
                   : (w_quot > DIV_W'(Z_MAX)) ? Z_MAX : w_quot[15:0];
    assign w_s     = (w_quot > DIV_W'(SCORE_ONE)) ? SCORE_ONE : w_quot[15:0];
    assign w_ftype = (r_feat == FEAT_LEN) ? TYPE_LENGTH
                   : (r_feat == FEAT_ENT) ? TYPE_ENTROPY : TYPE_TIMING;
    assign w_judge = (r_op == OP_ANALYZE) && !r_warm && (r_sd != '0) &&
                     (r_z > r_zthr) &&
                     (r_feat != FEAT_IV || (r_last != '0 && r_mean != '0));

    assign w_det     = (r_op == OP_ANALYZE) && !r_warm;
    assign w_rec     = (r_op == OP_ANALYZE) || (r_op == OP_RECORD);
    assign w_ana_nx  = (r_op == OP_CLEAR) ? 32'd0
                     : (r_op == OP_ANALYZE && r_ana != TOTAL_MAX) ? r_ana + 32'd1 : r_ana;
    assign w_anom_nx = (r_op == OP_CLEAR) ? 32'd0
                     : (r_op == OP_ANALYZE && r_type != TYPE_NONE && r_anom != TOTAL_MAX)
                       ? r_anom + 32'd1 : r_anom;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_MEAN;
            S_MEAN:  if (w_div_done) n_state = S_VAR;
            S_VAR:   if (w_div_done) n_state = S_MUL;
            S_MUL:   n_state = S_SQRT;
            S_SQRT:  if (w_sqrt_done) n_state = S_Z;
            S_Z:     if (w_div_done) n_state = S_SCORE;
            S_SCORE: begin
                if (w_div_done) n_state = (r_feat == FEAT_IV) ? S_DONE : S_MEAN;
            end
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_feat      <= FEAT_LEN;
            r_out_valid <= 1'b0;
            r_zthr      <= Z_THRESHOLD_RST;
            r_mins      <= MIN_SAMPLES_RST;
            r_cnt_s     <= '0;
            r_cnt_i     <= '0;
            r_last      <= '0;
            r_ana       <= '0;
            r_anom      <= '0;
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= '0;
                r_sq[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_Z_THRESHOLD: r_zthr <= i_cfg_data[15:0];
                    CFG_MIN_SAMPLES: r_mins <= i_cfg_data;
                    default: r_mins <= r_mins;
                endcase
            end
            if (w_div_start || w_sqrt_start) begin
                r_go <= 1'b1;
            end else if (w_div_done || w_sqrt_done) begin
                r_go <= 1'b0;
            end
            if (w_in_acc) begin
                r_feat <= FEAT_LEN;
            end else if (r_state == S_SCORE && w_div_done && r_feat != FEAT_IV) begin
                r_feat <= r_feat + 2'd1;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_fire) begin
                r_ana       <= w_ana_nx;
                r_anom      <= w_anom_nx;
                if (w_rec) begin
                    if (r_cnt_s < CNT_MAX) begin
                        r_cnt_s  <= r_cnt_s + COUNT_BITS'(1);
                        r_sum[0] <= r_sum[0] + SUM_W'(r_xv[0]);
                        r_sq[0]  <= r_sq[0] + SQ_W'(r_xsq[0]);
                        r_sum[1] <= r_sum[1] + SUM_W'(r_xv[1]);
                        r_sq[1]  <= r_sq[1] + SQ_W'(r_xsq[1]);
                    end
                    if (r_last != '0 && r_cnt_i < CNT_MAX) begin
                        r_cnt_i  <= r_cnt_i + COUNT_BITS'(1);
                        r_sum[2] <= r_sum[2] + SUM_W'(r_xv[2]);
                        r_sq[2]  <= r_sq[2] + SQ_W'(r_xsq[2]);
                    end
                    r_last <= r_now;
                end else if (r_op == OP_CLEAR) begin
                    r_cnt_s <= '0;
                    r_cnt_i <= '0;
                    r_last  <= '0;
                    for (int i = 0; i < 3; i++) begin
                        r_sum[i] <= '0;
                        r_sq[i]  <= '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op    <= i_in_data.opcode;
            r_xv[0] <= w_len;
            r_xv[1] <= X_W'(i_in_data.entropy_value);
            r_xv[2] <= w_iv;
            r_now   <= i_in_data.timestamp_ms;
            r_warm  <= w_warm;
            r_best  <= '0;
            r_type  <= TYPE_NONE;
            r_lz    <= '0;
        end
        if (r_state == S_MEAN && w_div_done) begin
            r_mean <= w_mean;
            if (r_feat == FEAT_LEN) r_lmean <= w_mean;
        end
        if (r_state == S_VAR) begin
            if (!r_go) begin
                r_xsq[r_feat] <= (2*X_W)'(r_xv[r_feat]) * (2*X_W)'(r_xv[r_feat]);
            end
            if (w_div_done) r_q <= w_quot[VAR_W-1:0];
        end
        if (r_state == S_MUL) begin
            r_mm <= VAR_W'(r_mean) * VAR_W'(r_mean);
        end
        if (r_state == S_SQRT && w_sqrt_done) begin
            r_sd <= w_root;
            if (r_feat == FEAT_LEN) r_lsd <= w_root;
        end
        if (r_state == S_Z && w_div_done) begin
            r_z <= w_z;
            if (r_feat == FEAT_LEN) r_lz <= w_z;
        end
        if (r_state == S_SCORE && w_div_done && w_judge && w_s > r_best) begin
            r_best <= w_s;
            r_type <= w_ftype;
        end
        if (w_fire) begin
            r_out.anomaly_type   <= w_det ? r_type : TYPE_NONE;
            r_out.anomaly_score  <= w_det ? r_best : 16'h0000;
            r_out.length_z       <= w_det ? r_lz : 16'h0000;
            r_out.warming_up     <= (r_op == OP_ANALYZE) && r_warm;
            r_out.mean_length    <= (r_lmean > MEAN_W'(STAT_MAX)) ? STAT_MAX : r_lmean[23:0];
            r_out.stddev_length  <= (r_lsd > MEAN_W'(STAT_MAX)) ? STAT_MAX : r_lsd[23:0];
            r_out.anomaly_total  <= w_anom_nx;
            r_out.analyzed_total <= w_ana_nx;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_MEAN && r_feat == FEAT_LEN))
        else $error("accepted item did not start the feature sweep");

    a_anom_le_ana: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_anom <= r_ana)
        else $error("anomaly count exceeds analyzed count");

    a_feat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_feat <= FEAT_IV)
        else $error("feature index out of range");

    a_warm_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.warming_up) |->
        (o_out_data.anomaly_type == TYPE_NONE && o_out_data.anomaly_score == 16'h0000))
        else $error("warm-up item reports an anomaly");
`endif

endmodule

@@ dv/zscore_anomaly_detector_core_test.sv @@
// Testbench for zscore_anomaly_detector_core: drives request items, writes both registers
// between phases, and checks every result against a built-in running z-score predictor.
// Depends on zad_pkg and the detector RTL.
module zscore_anomaly_detector_core_test;
    import zad_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [63:0] COUNT_FULL = 64'hFFFFF;
    localparam logic [63:0] IV_FULL = 64'hFFFFF;
    localparam int DRAIN_CYCLES = 800;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_item    in_data = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = CFG_Z_THRESHOLD;
    logic [19:0] cfg_data = '0;
    logic        o_in_ready, o_out_valid, o_cfg_ready;
    t_out_item   o_out_data;

    t_out_item expected_results[$];
    int        errors = 0;
    int        sent = 0;
    bit        quiet = 1'b0;
    int        stall_left = 0;

    // predictor state
    logic [63:0]  smp_cnt, len_sum, ent_sum, iv_cnt, iv_sum, last_t, n_analyzed, n_anom;
    logic [127:0] len_sq, ent_sq, iv_sq;
    logic [15:0]  thr;
    logic [19:0]  min_smp;

    zscore_anomaly_detector_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(o_in_ready), .i_in_data(in_data),
        .o_out_valid(o_out_valid), .i_out_ready(out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [63:0] mean_q8(logic [63:0] s, logic [63:0] n);
        return n != 0 ? (s << 8) / n : 64'd0;
    endfunction

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] sd_q8(logic [63:0] s, logic [127:0] sq, logic [63:0] n);
        logic [255:0] q;
        logic [63:0]  m, qs, mm;
        if (n < 2) return 64'd0;
        m = mean_q8(s, n);
        q = {128'd0, sq} << 16;
        q = q / {192'd0, n};
        qs = (q[255:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
        mm = m * m;
        return qs > mm ? root64(qs - mm) : 64'd0;
    endfunction

    function automatic logic [63:0] z_q8(logic [63:0] x, logic [63:0] mean, logic [63:0] sd);
        logic [63:0] xq, d, z;
        if (sd == 0) return 64'd0;
        xq = x << 8;
        d = xq > mean ? xq - mean : mean - xq;
        z = (d << 8) / sd;
        return z > 64'd65535 ? 64'd65535 : z;
    endfunction

    function automatic void rate_feature(logic [63:0] z, logic [1:0] kind,
                                         inout logic [63:0] best, inout logic [1:0] win);
        logic [63:0] s;
        if (z <= {48'd0, thr}) return;
        s = ((z - thr) * 128) / 3;
        if (s > 64'd32768) s = 64'd32768;
        if (s > best) begin
            best = s;
            win = kind;
        end
    endfunction

    function automatic logic [63:0] interval_to(logic [63:0] now);
        logic [63:0] d;
        if (now < last_t) return IV_FULL;
        d = now - last_t;
        return d > IV_FULL ? IV_FULL : d;
    endfunction

    function automatic void record_sample(logic [63:0] len, logic [63:0] ent, logic [63:0] now);
        logic [63:0] iv;
        if (smp_cnt < COUNT_FULL) begin
            smp_cnt = smp_cnt + 1;
            len_sum = len_sum + len;
            len_sq = len_sq + len * len;
            ent_sum = ent_sum + ent;
            ent_sq = ent_sq + ent * ent;
        end
        if (last_t != 0 && iv_cnt < COUNT_FULL) begin
            iv = interval_to(now);
            iv_cnt = iv_cnt + 1;
            iv_sum = iv_sum + iv;
            iv_sq = iv_sq + iv * iv;
        end
        last_t = now;
    endfunction

    function automatic void clear_stats();
        smp_cnt = 0; len_sum = 0; len_sq = 0; ent_sum = 0; ent_sq = 0;
        iv_cnt = 0; iv_sum = 0; iv_sq = 0; last_t = 0; n_analyzed = 0; n_anom = 0;
    endfunction

    function automatic t_out_item predict_detection(t_in_item it);
        t_out_item   r;
        logic [63:0] len, ent, now, lmean, lsd, score, lz, em, esd, im, isd;
        logic [1:0]  win;
        logic        warm;
        len = it.request_length;
        ent = it.entropy_value;
        now = it.timestamp_ms;
        lmean = mean_q8(len_sum, smp_cnt);
        lsd = sd_q8(len_sum, len_sq, smp_cnt);
        win = TYPE_NONE;
        score = 0;
        lz = 0;
        warm = 1'b0;
        case (it.opcode)
            OP_ANALYZE: begin
                if (n_analyzed < 64'hFFFF_FFFF) n_analyzed = n_analyzed + 1;
                if (smp_cnt < min_smp) begin
                    warm = 1'b1;
                end else begin
                    em = mean_q8(ent_sum, smp_cnt);
                    esd = sd_q8(ent_sum, ent_sq, smp_cnt);
                    lz = z_q8(len, lmean, lsd);
                    if (lsd != 0) rate_feature(lz, TYPE_LENGTH, score, win);
                    if (esd != 0) rate_feature(z_q8(ent, em, esd), TYPE_ENTROPY, score, win);
                    if (last_t != 0) begin
                        im = mean_q8(iv_sum, iv_cnt);
                        isd = sd_q8(iv_sum, iv_sq, iv_cnt);
                        if (isd != 0 && im != 0)
                            rate_feature(z_q8(interval_to(now), im, isd), TYPE_TIMING,
                                         score, win);
                    end
                end
                record_sample(len, ent, now);
                if (win != TYPE_NONE && n_anom < 64'hFFFF_FFFF) n_anom = n_anom + 1;
            end
            OP_RECORD: record_sample(len, ent, now);
            OP_CLEAR: clear_stats();
            default: ;
        endcase
        r.anomaly_type = win;
        r.anomaly_score = score[15:0];
        r.length_z = lz[15:0];
        r.warming_up = warm;
        r.mean_length = lmean > 64'hFFFFFF ? STAT_MAX : lmean[23:0];
        r.stddev_length = lsd > 64'hFFFFFF ? STAT_MAX : lsd[23:0];
        r.anomaly_total = n_anom[31:0];
        r.analyzed_total = n_analyzed[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (o_out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item", 0, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.anomaly_type !== want.anomaly_type)
                    report_mismatch("anomaly_type", o_out_data.anomaly_type, want.anomaly_type);
                if (o_out_data.anomaly_score !== want.anomaly_score)
                    report_mismatch("anomaly_score", o_out_data.anomaly_score, want.anomaly_score);
                if (o_out_data.length_z !== want.length_z)
                    report_mismatch("length_z", o_out_data.length_z, want.length_z);
                if (o_out_data.warming_up !== want.warming_up)
                    report_mismatch("warming_up", o_out_data.warming_up, want.warming_up);
                if (o_out_data.mean_length !== want.mean_length)
                    report_mismatch("mean_length", o_out_data.mean_length, want.mean_length);
                if (o_out_data.stddev_length !== want.stddev_length)
                    report_mismatch("stddev_length", o_out_data.stddev_length,
                                    want.stddev_length);
                if (o_out_data.anomaly_total !== want.anomaly_total)
                    report_mismatch("anomaly_total", o_out_data.anomaly_total, want.anomaly_total);
                if (o_out_data.analyzed_total !== want.analyzed_total)
                    report_mismatch("analyzed_total", o_out_data.analyzed_total,
                                    want.analyzed_total);
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 11);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_item(logic [1:0] op, logic [15:0] len, logic [15:0] ent,
                             logic [47:0] ts);
        t_in_item it;
        it.opcode = op;
        it.request_length = len;
        it.entropy_value = ent;
        it.timestamp_ms = ts;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.push_back(predict_detection(it));
        sent++;
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(logic [15:0] z_thr, logic [19:0] min_s);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_Z_THRESHOLD;
        cfg_data <= {4'd0, z_thr};
        do @(posedge i_clk); while (!o_cfg_ready);
        thr = z_thr;
        cfg_index <= CFG_MIN_SAMPLES;
        cfg_data <= min_s;
        do @(posedge i_clk); while (!o_cfg_ready);
        min_smp = min_s;
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        int i;
        send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
        send_item(OP_CLEAR, 16'd5, 16'd5, 48'd5);
        send_item(OP_ANALYZE, 16'd0, 16'd0, 48'd0);
        send_item(OP_RECORD, 16'hFFFF, 16'd32768, 48'd1000);
        send_item(OP_RECORD, 16'd100, 16'hFFFF, 48'd2000);
        send_item(OP_RECORD, 16'd0, 16'd0, 48'd1500);
        send_item(OP_RECORD, 16'd300, 16'd4096, 48'hFFFF_FFFF_FFFF);
        send_item(OP_RECORD, 16'd200, 16'd100, 48'd0);
        wait_idle();
        write_config(16'd0, 20'd0);
        send_item(OP_ANALYZE, 16'hFFFF, 16'd32768, 48'd10);
        send_item(OP_ANALYZE, 16'd0, 16'd0, 48'd30);
        send_item(OP_ANALYZE, 16'd120, 16'd2000, 48'd40);
        wait_idle();
        write_config(16'hFFFF, 20'hFFFFF);
        send_item(OP_ANALYZE, 16'd50, 16'd50, 48'd50);
        wait_idle();
        write_config(16'd768, 20'd3);
        send_item(OP_CLEAR, 16'd0, 16'd0, 48'd0);
        for (i = 0; i < 6; i++)
            send_item(OP_RECORD, 16'd500 + i[15:0], 16'd16000 + 16'(i * 7),
                      48'd1000 + 48'(i * 100 + i % 2));
        send_item(OP_ANALYZE, 16'd9000, 16'd16003, 48'd1601);
        send_item(OP_ANALYZE, 16'd502, 16'd32768, 48'd1701);
        send_item(OP_ANALYZE, 16'd503, 16'd16002, 48'd90000);
        send_item(OP_ANALYZE, 16'd501, 16'd16001, 48'd90100);
        wait_idle();
    endtask

    task automatic test_random(int total);
        int          n, k, roll;
        logic [15:0] base_len, spread, base_ent, esp, len, ent;
        logic [47:0] t, period, jit, ts;
        logic [1:0]  op;
        while (sent < total) begin
            if (total - sent < 120) quiet = 1'b1;
            case ($urandom_range(0, 5))
                0: write_config(16'($urandom), 20'($urandom));
                1: write_config(16'd0, 20'($urandom_range(0, 3)));
                default: write_config(16'($urandom_range(128, 1200)),
                                      20'($urandom_range(0, 30)));
            endcase
            if ($urandom_range(0, 1)) send_item(OP_CLEAR, 16'($urandom), 16'($urandom), 48'd0);
            base_len = 16'($urandom_range(0, 65535));
            spread = 16'($urandom_range(1, 300));
            base_ent = 16'($urandom_range(0, 32768));
            esp = 16'($urandom_range(1, 800));
            t = {16'($urandom), 32'($urandom)};
            period = 48'($urandom_range(1, 5000));
            jit = 48'($urandom_range(0, 50));
            n = $urandom_range(40, 120);
            for (k = 0; k < n && sent < total; k++) begin
                roll = $urandom_range(0, 99);
                t = t + period + 48'($urandom_range(0, 32'(jit)));
                len = base_len + 16'($urandom_range(0, 32'(spread)));
                ent = base_ent + 16'($urandom_range(0, 32'(esp)));
                ts = t;
                op = ($urandom_range(0, 3) == 0) ? OP_RECORD : OP_ANALYZE;
                if (roll < 5) len = 16'($urandom);
                else if (roll < 10) ent = 16'($urandom);
                else if (roll < 14) ts = t + 48'($urandom_range(1000, 200000));
                else if (roll < 16) ts = 48'd0;
                else if (roll < 18) ts = t - 48'($urandom_range(1, 1000));
                else if (roll < 19) op = OP_CLEAR;
                else if (roll < 20) op = OP_UNUSED;
                else if (roll < 26) begin
                    op = 2'($urandom);
                    len = 16'($urandom);
                    ent = 16'($urandom);
                    ts = {16'($urandom), 32'($urandom)};
                end
                send_item(op, len, ent, ts);
            end
            wait_idle();
        end
    endtask

    initial begin
        thr = Z_THRESHOLD_RST;
        min_smp = MIN_SAMPLES_RST;
        clear_stats();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1100);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #300ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
